// ===== rtl/md2_pkg.sv =====
package md2_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int WORK_BYTES  = 48;
    localparam int ROUNDS      = 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } md2_state_t;

    typedef enum logic [1:0] {
        BLK_MSG,
        BLK_PAD,
        BLK_CKS
    } md2_block_kind_t;

    localparam logic [7:0] PI_SBOX [256] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

endpackage

// ===== rtl/md2_if.sv =====
interface md2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface md2_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    modport source (output valid, output digest_high, output digest_low, input ready);
    modport sink   (input valid, input digest_high, input digest_low, output ready);
endinterface

// ===== rtl/md2_hash_engine_core.sv =====
// MD2 digest engine, byte-serial.
// msg_in (sink): one beat carries an optional message byte (has_byte) and an
// optional end_of_message mark; ready is high only while the engine waits for
// input. digest_out (source): one beat per message, the 16-byte digest split
// into digest_high (bytes 0..7) and digest_low (bytes 8..15), byte 0 on top.
// Every sixteenth byte starts a block transform: a load step (ST_LOAD), 18
// rounds of 48 S-box steps through the 48-byte work shift register, and a
// write-back step (ST_FINISH). The checksum update runs in the first 16
// S-box steps of the first round. End of message appends 1 to 16 padding
// bytes, then runs the padding block transform and the checksum block
// transform before the digest beat appears.
// The digest sits in an output register, so a stalled receiver does not hold
// up the next message; only a second digest waits in write-back until the
// first is taken. Reset clears hash state, checksum and byte count.
module md2_hash_engine_core
    import md2_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    md2_in_if.sink        msg_in,
    md2_out_if.source     digest_out
);

    md2_state_t      state_reg, state_next;
    md2_block_kind_t kind_reg;

    logic [7:0] hash_reg [BLOCK_BYTES];
    logic [7:0] cks_reg  [BLOCK_BYTES];
    logic [7:0] blk_reg  [BLOCK_BYTES];
    logic [7:0] work_reg [WORK_BYTES];

    logic [3:0] cnt_reg;
    logic [7:0] pad_reg;
    logic       fin_reg;
    logic [7:0] t_reg;
    logic [7:0] ct_reg;
    logic [5:0] step_reg;
    logic [4:0] round_reg;

    logic        out_valid_reg;
    logic [63:0] out_high_reg;
    logic [63:0] out_low_reg;

    logic        accept;
    logic        block_full;
    logic [3:0]  cnt_inc;
    logic [7:0]  work_new;
    logic [7:0]  cks_new;
    logic        round_end;
    logic        last_step;
    logic        cks_step;
    logic        out_free;
    logic [63:0] dig_high;
    logic [63:0] dig_low;

    assign msg_in.ready           = (state_reg == ST_IDLE);
    assign digest_out.valid       = out_valid_reg;
    assign digest_out.digest_high = out_high_reg;
    assign digest_out.digest_low  = out_low_reg;

    assign accept     = msg_in.valid && msg_in.ready;
    assign block_full = msg_in.has_byte && (cnt_reg == 4'd15);
    assign cnt_inc    = msg_in.has_byte ? cnt_reg + 4'd1 : cnt_reg;
    assign work_new   = work_reg[0] ^ PI_SBOX[t_reg];
    assign cks_new    = cks_reg[0] ^ PI_SBOX[blk_reg[0] ^ ct_reg];
    assign round_end  = (step_reg == 6'(WORK_BYTES - 1));
    assign last_step  = round_end && (round_reg == 5'(ROUNDS - 1));
    assign cks_step   = (round_reg == 5'd0) && (step_reg < 6'(BLOCK_BYTES));
    assign out_free   = !out_valid_reg || digest_out.ready;

    // After the last round the work register is back in its original order.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            dig_high[63 - 8 * k -: 8] = work_reg[k];
            dig_low[63 - 8 * k -: 8]  = work_reg[8 + k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (block_full)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg_in.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                case (kind_reg)
                    BLK_MSG: state_next = fin_reg ? ST_PAD : ST_IDLE;
                    BLK_PAD: state_next = ST_LOAD;
                    BLK_CKS: state_next = out_free ? ST_IDLE : ST_FINISH;
                    default: state_next = ST_IDLE;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and hash state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BLOCK_BYTES; k++)
            begin
                hash_reg[k] <= 8'd0;
                cks_reg[k]  <= 8'd0;
            end
            cnt_reg       <= 4'd0;
            fin_reg       <= 1'b0;
            kind_reg      <= BLK_MSG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FINISH && kind_reg == BLK_CKS && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digest_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg  <= cnt_inc;
                        fin_reg  <= msg_in.end_of_message;
                        kind_reg <= block_full ? BLK_MSG : BLK_PAD;
                    end
                end
                ST_PAD:
                begin
                    cnt_reg  <= cnt_reg + 4'd1;
                    kind_reg <= BLK_PAD;
                end
                ST_ROUND:
                begin
                    if (cks_step)
                    begin
                        for (int k = 0; k < BLOCK_BYTES - 1; k++)
                        begin
                            cks_reg[k] <= cks_reg[k + 1];
                        end
                        cks_reg[BLOCK_BYTES - 1] <= cks_new;
                    end
                end
                ST_FINISH:
                begin
                    if (kind_reg == BLK_CKS)
                    begin
                        if (out_free)
                        begin
                            for (int k = 0; k < BLOCK_BYTES; k++)
                            begin
                                hash_reg[k] <= 8'd0;
                                cks_reg[k]  <= 8'd0;
                            end
                            cnt_reg  <= 4'd0;
                            fin_reg  <= 1'b0;
                            kind_reg <= BLK_MSG;
                        end
                    end
                    else
                    begin
                        for (int k = 0; k < BLOCK_BYTES; k++)
                        begin
                            hash_reg[k] <= work_reg[k];
                        end
                        if (kind_reg == BLK_PAD)
                        begin
                            kind_reg <= BLK_CKS;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath shift registers and counters.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (msg_in.has_byte)
                    begin
                        for (int k = 0; k < BLOCK_BYTES - 1; k++)
                        begin
                            blk_reg[k] <= blk_reg[k + 1];
                        end
                        blk_reg[BLOCK_BYTES - 1] <= msg_in.data_byte;
                    end
                    pad_reg <= 8'(5'd16 - {1'b0, cnt_inc});
                end
            end
            ST_PAD:
            begin
                for (int k = 0; k < BLOCK_BYTES - 1; k++)
                begin
                    blk_reg[k] <= blk_reg[k + 1];
                end
                blk_reg[BLOCK_BYTES - 1] <= pad_reg;
            end
            ST_LOAD:
            begin
                for (int k = 0; k < BLOCK_BYTES; k++)
                begin
                    work_reg[k]                   <= hash_reg[k];
                    work_reg[BLOCK_BYTES + k]     <= blk_reg[k];
                    work_reg[2 * BLOCK_BYTES + k] <= hash_reg[k] ^ blk_reg[k];
                end
                t_reg     <= 8'd0;
                ct_reg    <= cks_reg[BLOCK_BYTES - 1];
                step_reg  <= 6'd0;
                round_reg <= 5'd0;
            end
            ST_ROUND:
            begin
                for (int k = 0; k < WORK_BYTES - 1; k++)
                begin
                    work_reg[k] <= work_reg[k + 1];
                end
                work_reg[WORK_BYTES - 1] <= work_new;
                if (round_end)
                begin
                    t_reg     <= work_new + 8'(round_reg);
                    step_reg  <= 6'd0;
                    round_reg <= round_reg + 5'd1;
                end
                else
                begin
                    t_reg    <= work_new;
                    step_reg <= step_reg + 6'd1;
                end
                if (cks_step)
                begin
                    // The message block rotates past the checksum step once.
                    for (int k = 0; k < BLOCK_BYTES - 1; k++)
                    begin
                        blk_reg[k] <= blk_reg[k + 1];
                    end
                    blk_reg[BLOCK_BYTES - 1] <= blk_reg[0];
                    ct_reg <= cks_new;
                end
            end
            ST_FINISH:
            begin
                if (kind_reg == BLK_MSG)
                begin
                    pad_reg <= 8'd16;
                end
                else if (kind_reg == BLK_PAD)
                begin
                    for (int k = 0; k < BLOCK_BYTES; k++)
                    begin
                        blk_reg[k] <= cks_reg[k];
                    end
                end
                else if (kind_reg == BLK_CKS && out_free)
                begin
                    out_high_reg <= dig_high;
                    out_low_reg  <= dig_low;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
